FILE: rtl/core/tdq_pkg.sv
// tdq_pkg: shared types and constants of the turn-tagged drop queue.
// Used by every module in rtl/core except tdq_ram; no dependencies.
`timescale 1ns / 1ps

package tdq_pkg;

	localparam int TURN_W    = 16;
	localparam int HANDLE_W  = 32;
	localparam int SAMPLE_W  = 16;
	localparam int CMD_W     = 3;
	localparam int CAP_W     = 7;
	localparam int CNT_OUT_W = 7;
	localparam int PEND_W    = 22;
	localparam int TOT_W     = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ  = 3'd0,
		CMD_DEQ  = 3'd1,
		CMD_INV  = 3'd2,
		CMD_CLR  = 3'd3,
		CMD_SIZE = 3'd4,
		CMD_PEND = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_EXEC,
		SQ_WALK,
		SQ_DONE
	} seq_state_t;

	// queue entry, turn in the low bits
	typedef struct packed {
		logic [SAMPLE_W-1:0] samples;
		logic [HANDLE_W-1:0] handle;
		logic [TURN_W-1:0]   turn;
	} entry_t;

	typedef struct packed {
		logic [TOT_W-1:0]     deq_total;
		logic [TOT_W-1:0]     enq_total;
		logic [TOT_W-1:0]     drop_total;
		logic [PEND_W-1:0]    pending;
		logic [CNT_OUT_W-1:0] occupancy;
		logic [CNT_OUT_W-1:0] dropped;
		logic [SAMPLE_W-1:0]  samples;
		logic [HANDLE_W-1:0]  handle;
		logic [TURN_W-1:0]    turn;
	} res_t;

	typedef struct packed {
		logic              eq;
		logic              lt;
		logic [PEND_W-1:0] sum;
	} unit_res_t;

	localparam int IN_DATA_W  = $bits(entry_t);
	localparam int RES_W      = $bits(res_t);
	localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

endpackage

FILE: rtl/core/tdq_ram.sv
// tdq_ram: single write port, single registered read port entry store.
// No dependencies.
`timescale 1ns / 1ps

module tdq_ram #(
	parameter int DEPTH = 64,
	parameter int W     = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/tdq_unit.sv
// tdq_unit: shared turn compare and sample accumulate unit.
// Depends on tdq_pkg.
`timescale 1ns / 1ps

module tdq_unit (
	input  tdq_pkg::entry_t                ent,
	input  logic [tdq_pkg::TURN_W-1:0]     key_turn,
	input  logic [tdq_pkg::PEND_W-1:0]     acc,
	output tdq_pkg::unit_res_t             res
);

	import tdq_pkg::*;

	always_comb begin
		res.eq  = (ent.turn == key_turn);
		res.lt  = (ent.turn < key_turn);
		res.sum = acc + PEND_W'(ent.samples);
	end

endmodule

FILE: rtl/core/tdq_seq.sv
// tdq_seq: command sequencer; walks the queue one entry a cycle through the
// entry store and the shared compare unit. Depends on tdq_pkg, tdq_ram, tdq_unit.
`timescale 1ns / 1ps

module tdq_seq #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  tdq_pkg::cmd_t             cmd_in,
	input  tdq_pkg::entry_t           item_in,
	input  logic [tdq_pkg::CAP_W-1:0] capacity,
	input  logic                      out_free,
	output logic                      idle,
	output logic                      res_valid,
	output logic                      res_ok,
	output tdq_pkg::res_t             res
);

	import tdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	seq_state_t state_q, state_d;
	cmd_t       cmd_q;
	entry_t     key_q;
	entry_t     hit_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_idx_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     ndrop_q;
	logic              vld_s1;
	logic              ok_q;
	logic [PEND_W-1:0] acc_q;
	logic [TOT_W-1:0]  drop_cnt_q, enq_cnt_q, deq_cnt_q;

	logic       we, re, issue, enq_wr, inv_wr, full, walk_end, found;
	logic [AW-1:0] waddr, raddr;
	entry_t     wdata, rdata;
	unit_res_t  u;
	logic [EW-1:0] eff_cap;
	logic [CW-1:0] adv;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	tdq_ram #(.DEPTH(DEPTH), .W(IN_DATA_W)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	tdq_unit u_unit (
		.ent     (rdata),
		.key_turn(key_q.turn),
		.acc     (acc_q),
		.res     (u)
	);

	assign eff_cap  = (EW'(capacity) > EW'(DEPTH)) ? EW'(DEPTH) : EW'(capacity);
	assign full     = (EW'(count_q) >= eff_cap);
	assign found    = (cmd_q == CMD_DEQ) && vld_s1 && u.eq;
	assign walk_end = (!vld_s1 && rd_idx_q == count_q) || found;
	assign adv      = ndrop_q + CW'(found);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					state_d = (cmd_in inside {CMD_DEQ, CMD_INV, CMD_PEND}) ? SQ_WALK : SQ_EXEC;
				end
			end
			SQ_EXEC: state_d = SQ_DONE;
			SQ_WALK: begin
				if (walk_end) begin
					state_d = SQ_DONE;
				end
			end
			SQ_DONE: begin
				if (out_free) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		idle      = (state_q == SQ_IDLE);
		res_valid = (state_q == SQ_DONE) && out_free;
		issue     = (state_q == SQ_WALK) && (rd_idx_q != count_q);
		re        = issue;
		raddr     = slot(head_q, rd_idx_q);
		enq_wr    = (state_q == SQ_EXEC) && (cmd_q == CMD_ENQ) && !full;
		inv_wr    = (state_q == SQ_WALK) && (cmd_q == CMD_INV) && vld_s1 && !u.lt;
		we        = enq_wr || inv_wr;
		waddr     = enq_wr ? slot(head_q, count_q) : slot(head_q, k_q);
		wdata     = enq_wr ? key_q : rdata;
	end

	always_ff @(posedge clk) begin
		if (start && state_q == SQ_IDLE) begin
			key_q <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SQ_IDLE;
			cmd_q      <= CMD_SIZE;
			hit_q      <= '0;
			head_q     <= '0;
			count_q    <= '0;
			rd_idx_q   <= '0;
			k_q        <= '0;
			ndrop_q    <= '0;
			vld_s1     <= 1'b0;
			ok_q       <= 1'b0;
			acc_q      <= '0;
			drop_cnt_q <= '0;
			enq_cnt_q  <= '0;
			deq_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				SQ_IDLE: begin
					if (start) begin
						cmd_q    <= cmd_in;
						hit_q    <= '0;
						rd_idx_q <= '0;
						k_q      <= '0;
						ndrop_q  <= '0;
						vld_s1   <= 1'b0;
						ok_q     <= 1'b0;
						acc_q    <= '0;
					end
				end
				SQ_EXEC: begin
					case (cmd_q)
						CMD_ENQ: begin
							if (full) begin
								ndrop_q    <= CW'(1);
								drop_cnt_q <= drop_cnt_q + 1'b1;
							end else begin
								count_q   <= count_q + 1'b1;
								enq_cnt_q <= enq_cnt_q + 1'b1;
								ok_q      <= 1'b1;
							end
						end
						CMD_CLR: begin
							ndrop_q    <= count_q;
							drop_cnt_q <= drop_cnt_q + TOT_W'(count_q);
							count_q    <= '0;
						end
						default: ;
					endcase
				end
				SQ_WALK: begin
					vld_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (vld_s1) begin
						case (cmd_q)
							CMD_DEQ: begin
								if (u.eq) begin
									hit_q <= rdata;
									ok_q  <= 1'b1;
								end else begin
									ndrop_q <= ndrop_q + 1'b1;
								end
							end
							CMD_INV: begin
								if (u.lt) begin
									ndrop_q <= ndrop_q + 1'b1;
								end else begin
									k_q <= k_q + 1'b1;
								end
							end
							CMD_PEND: begin
								if (u.eq) begin
									acc_q <= u.sum;
								end
							end
							default: ;
						endcase
					end
					if (walk_end) begin
						drop_cnt_q <= drop_cnt_q + TOT_W'(ndrop_q);
						case (cmd_q)
							CMD_DEQ: begin
								head_q  <= slot(head_q, adv);
								count_q <= count_q - adv;
								if (found) begin
									deq_cnt_q <= deq_cnt_q + 1'b1;
								end
							end
							CMD_INV: count_q <= k_q;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res_ok         = ok_q;
		res.turn       = hit_q.turn;
		res.handle     = hit_q.handle;
		res.samples    = hit_q.samples;
		res.dropped    = CNT_OUT_W'(ndrop_q);
		res.occupancy  = CNT_OUT_W'(count_q);
		res.pending    = acc_q;
		res.drop_total = drop_cnt_q;
		res.enq_total  = enq_cnt_q;
		res.deq_total  = deq_cnt_q;
	end

endmodule

FILE: rtl/core/turn_tagged_drop_queue.sv
// turn_tagged_drop_queue: bounded FIFO of chunk descriptors with turn flushing.
// Depends on tdq_pkg and tdq_seq (which holds tdq_ram and tdq_unit).
//
// Usage:
//   Commands enter on the s_ stream: s_tuser carries the command code and s_tdata
//   the turn, handle and sample count. Every command yields exactly one result word
//   on the m_ stream. The capacity register is written on cfg_valid (cfg_ready is
//   always high). Write it only while the block is idle; the block does not check.
// Command flow:
//   Enqueue, clear, size and unknown codes do not walk the queue. Dequeue,
//   invalidate and pending-sum walk the queue through the entry store, one
//   entry per cycle, up to the occupancy; a dequeue stops at the first hit.
//   The single read port of the entry store sets this rate. One command is in
//   work at a time; s_tready is high only when idle, so a new command is taken
//   only after the sequencer has handed on the last result.
// Reset:
//   arst_n clears the queue, all counters and the output valid and sets
//   capacity to 64. The entry store is not cleared.
// Stall:
//   A result waits in the output register until m_tready; the sequencer
//   holds its finished result until that register is free.
`timescale 1ns / 1ps

module turn_tagged_drop_queue #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [tdq_pkg::IN_DATA_W-1:0]   s_tdata,  // turn_id, chunk_handle, sample_count
	input  logic [tdq_pkg::CMD_W-1:0]       s_tuser,  // command
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_turn, out_handle, out_samples, dropped_now, occupancy, pending_total,
	// drop_total, enqueue_total, dequeue_total, zero pad
	output logic [tdq_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser,  // ok
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tdq_pkg::CAP_W-1:0]       cfg_data  // capacity
);

	import tdq_pkg::*;

	logic [CAP_W-1:0]      capacity_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_ok_q;
	logic                  out_free, idle, res_valid, res_ok;
	res_t                  res;

	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = idle;

	tdq_seq #(.DEPTH(DEPTH)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && idle),
		.cmd_in   (cmd_t'(s_tuser)),
		.item_in  (entry_t'(s_tdata)),
		.capacity (capacity_q),
		.out_free (out_free),
		.idle     (idle),
		.res_valid(res_valid),
		.res_ok   (res_ok),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (res_valid) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_data_q <= OUT_DATA_W'(res);
			m_ok_q   <= res_ok;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_ok_q;

endmodule
